### src/rgbds_pkg.sv
// ----------------------------------------------------------------------------
// rgbds_pkg: shared types and constants of the RGB565 downscaler
// Field widths, register indexes and reset values, color weights, queue types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rgbds_pkg;

  localparam int MAX_DIM_DEFAULT = 1024;

  localparam int BYTE_W   = 8;
  localparam int COORD_W  = 10;
  localparam int CFG_W    = 11;
  localparam int RED_W    = 13;
  localparam int GREEN_W  = 14;
  localparam int BLUE_W   = 12;

  // luma-style weights applied to the expanded 8-bit channels
  localparam logic [RED_W-1:0]   RED_WEIGHT   = RED_W'(30);
  localparam logic [GREEN_W-1:0] GREEN_WEIGHT = GREEN_W'(59);
  localparam logic [BLUE_W-1:0]  BLUE_WEIGHT  = BLUE_W'(11);

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DST_HEIGHT = 2'd3;

  localparam logic [CFG_W-1:0] SRC_WIDTH_RESET  = CFG_W'(160);
  localparam logic [CFG_W-1:0] SRC_HEIGHT_RESET = CFG_W'(120);
  localparam logic [CFG_W-1:0] DST_WIDTH_RESET  = CFG_W'(64);
  localparam logic [CFG_W-1:0] DST_HEIGHT_RESET = CFG_W'(64);

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;

  typedef struct packed {
    logic [CFG_W-1:0] src_width;
    logic [CFG_W-1:0] src_height;
    logic [CFG_W-1:0] dst_width;
    logic [CFG_W-1:0] dst_height;
  } cfg_regs_t;

  // one selected pixel, queued between selector and color stage
  typedef struct packed {
    logic [BYTE_W-1:0]  first_byte;
    logic [BYTE_W-1:0]  second_byte;
    logic [COORD_W-1:0] dest_col;
    logic [COORD_W-1:0] dest_row;
    logic               last_of_frame;
  } pick_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [CNT_W-1:0] count;
  } fifo_stat_t;

endpackage

`default_nettype wire

### src/rgbds_pix_if.sv
// ----------------------------------------------------------------------------
// rgbds_pix_if: source pixel channel
// One RGB565 pixel per word, low byte first, with a frame start mark.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rgbds_pix_if import rgbds_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] first_byte;
  logic [BYTE_W-1:0] second_byte;
  logic              frame_start;

  modport source(output valid, first_byte, second_byte, frame_start, input ready);
  modport sink(input valid, first_byte, second_byte, frame_start, output ready);
endinterface

`default_nettype wire

### src/rgbds_res_if.sv
// ----------------------------------------------------------------------------
// rgbds_res_if: result channel
// Destination coordinates and weighted color terms of one selected pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rgbds_res_if import rgbds_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] dest_col;
  logic [COORD_W-1:0] dest_row;
  logic [RED_W-1:0]   red_term;
  logic [GREEN_W-1:0] green_term;
  logic [BLUE_W-1:0]  blue_term;
  logic               last_of_frame;

  modport source(output valid, dest_col, dest_row, red_term, green_term, blue_term,
                 last_of_frame, input ready);
  modport sink(input valid, dest_col, dest_row, red_term, green_term, blue_term,
               last_of_frame, output ready);
endinterface

`default_nettype wire

### src/rgbds_cfg_if.sv
// ----------------------------------------------------------------------------
// rgbds_cfg_if: configuration write channel
// Register index and write data, one register per word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface rgbds_cfg_if import rgbds_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_W-1:0]       wdata;

  modport source(output valid, index, wdata, input ready);
  modport sink(input valid, index, wdata, output ready);
endinterface

`default_nettype wire

### src/rgbds_front.sv
// ----------------------------------------------------------------------------
// rgbds_front: pixel selector
// Tracks source position and steps the column and row selectors; queues
// every pixel that lands on a destination grid point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbds_front import rgbds_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_regs_t  regs,
  rgbds_pix_if.sink       pixel,
  input  wire fifo_stat_t stat,
  output logic            push,
  output pick_t           entry
);

  localparam int PW = $clog2(MAX_DIM);
  localparam int DW = PW + 1;
  localparam int CW = (DW > CFG_W) ? DW : CFG_W;

  function automatic logic [DW-1:0] clamp_dim(logic [CW-1:0] v, logic [CW-1:0] hi);
    logic [DW-1:0] r;
    if (v == '0) r = DW'(1);
    else if (v > hi) r = DW'(hi);
    else r = DW'(v);
    return r;
  endfunction

  logic [DW-1:0] sw, sh, dw, dh;

  logic [PW-1:0] source_col, source_row, target_col, target_row;
  logic [DW-1:0] col_remainder, row_remainder, out_col, out_row;
  logic [PW-1:0] source_col_next, source_row_next, target_col_next, target_row_next;
  logic [DW-1:0] col_remainder_next, row_remainder_next, out_col_next, out_row_next;
  logic          col_pick, row_pick, accept;

  assign sw = clamp_dim(CW'(regs.src_width), CW'(MAX_DIM));
  assign sh = clamp_dim(CW'(regs.src_height), CW'(MAX_DIM));
  assign dw = clamp_dim(CW'(regs.dst_width), CW'(sw));
  assign dh = clamp_dim(CW'(regs.dst_height), CW'(sh));

  assign pixel.ready = !stat.full;
  assign accept      = pixel.valid && pixel.ready;

  always_comb begin
    source_col_next    = source_col;
    source_row_next    = source_row;
    target_col_next    = target_col;
    target_row_next    = target_row;
    col_remainder_next = col_remainder;
    row_remainder_next = row_remainder;
    out_col_next       = out_col;
    out_row_next       = out_row;

    if (pixel.frame_start) begin
      source_col_next    = '0;
      source_row_next    = '0;
      target_col_next    = '0;
      target_row_next    = '0;
      col_remainder_next = '0;
      row_remainder_next = '0;
      out_col_next       = '0;
      out_row_next       = '0;
    end

    // invariant: target*D + remainder = out*S, one normalize step per column
    if (source_col_next == '0) begin
      target_col_next    = '0;
      col_remainder_next = '0;
      out_col_next       = '0;
      if (row_remainder_next >= dh) begin
        target_row_next    = target_row_next + 1'b1;
        row_remainder_next = row_remainder_next - dh;
      end
    end else if (col_remainder_next >= dw) begin
      target_col_next    = target_col_next + 1'b1;
      col_remainder_next = col_remainder_next - dw;
    end

    col_pick = (target_col_next == source_col_next) && (col_remainder_next < dw)
               && (out_col_next < dw);
    row_pick = (target_row_next == source_row_next) && (row_remainder_next < dh)
               && (out_row_next < dh);

    entry.first_byte    = pixel.first_byte;
    entry.second_byte   = pixel.second_byte;
    entry.dest_col      = COORD_W'(out_col_next);
    entry.dest_row      = COORD_W'(out_row_next);
    entry.last_of_frame = (out_col_next == dw - 1'b1) && (out_row_next == dh - 1'b1);

    if (col_pick) begin
      out_col_next       = out_col_next + 1'b1;
      col_remainder_next = col_remainder_next + sw;
    end

    if ({1'b0, source_col_next} >= sw - 1'b1) begin
      source_col_next = '0;
      if (row_pick) begin
        out_row_next       = out_row_next + 1'b1;
        row_remainder_next = row_remainder_next + sh;
      end
      if ({1'b0, source_row_next} >= sh - 1'b1) begin
        // frame wrap
        source_row_next    = '0;
        target_col_next    = '0;
        target_row_next    = '0;
        col_remainder_next = '0;
        row_remainder_next = '0;
        out_col_next       = '0;
        out_row_next       = '0;
      end else begin
        source_row_next = source_row_next + 1'b1;
      end
    end else begin
      source_col_next = source_col_next + 1'b1;
    end
  end

  assign push = accept && col_pick && row_pick;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_col    <= '0;
      source_row    <= '0;
      target_col    <= '0;
      target_row    <= '0;
      col_remainder <= '0;
      row_remainder <= '0;
      out_col       <= '0;
      out_row       <= '0;
    end else if (accept) begin
      source_col    <= source_col_next;
      source_row    <= source_row_next;
      target_col    <= target_col_next;
      target_row    <= target_row_next;
      col_remainder <= col_remainder_next;
      row_remainder <= row_remainder_next;
      out_col       <= out_col_next;
      out_row       <= out_row_next;
    end
  end

endmodule

`default_nettype wire

### src/rgbds_fifo.sv
// ----------------------------------------------------------------------------
// rgbds_fifo: selected-pixel queue
// Short register queue decoupling the selector from the color stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbds_fifo import rgbds_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire pick_t wr_entry,
  input  wire logic  pop,
  output pick_t      rd_entry,
  output fifo_stat_t stat
);

  pick_t            mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign rd_entry   = mem[rd_ptr];
  assign stat.count = count;
  assign stat.full  = (count == CNT_W'(FIFO_DEPTH));
  assign stat.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  // depth is a power of two, pointers wrap naturally
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

`default_nettype wire

### src/rgbds_back.sv
// ----------------------------------------------------------------------------
// rgbds_back: color stage and output register
// Expands RGB565 channels to 8 bits, applies the weights, holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgbds_back import rgbds_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire fifo_stat_t stat,
  input  wire pick_t      entry,
  output logic            pop,
  rgbds_res_if.source     result
);

  logic [BYTE_W-1:0] red8, green8, blue8;

  assign red8   = {entry.second_byte[7:3], 3'b000};
  assign green8 = {entry.second_byte[2:0], entry.first_byte[7:5], 2'b00};
  assign blue8  = {entry.first_byte[4:0], 3'b000};

  // load whenever the output slot is free or being drained this cycle
  assign pop = !stat.empty && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (pop) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.dest_col      <= entry.dest_col;
      result.dest_row      <= entry.dest_row;
      result.red_term      <= RED_W'(red8) * RED_WEIGHT;
      result.green_term    <= GREEN_W'(green8) * GREEN_WEIGHT;
      result.blue_term     <= BLUE_W'(blue8) * BLUE_WEIGHT;
      result.last_of_frame <= entry.last_of_frame;
    end
  end

endmodule

`default_nettype wire

### src/rgb565_nearest_downscaler_core.sv
// ----------------------------------------------------------------------------
// rgb565_nearest_downscaler_core: nearest-neighbor RGB565 frame downscaler
// Picks destination grid pixels from a raster source stream and emits
// their coordinates with weighted red, green and blue terms.
// ----------------------------------------------------------------------------
// Usage:
//   pixel  - one source pixel per word in raster order, frame_start on the
//            first pixel of a frame (frames also wrap on their own).
//   result - one word per selected pixel; last_of_frame marks the final one.
//   cfg    - writes source/destination width and height by index; write only
//            while no pixel is in flight. Always ready.
// Throughput: one pixel per clock while the queue is not full. The selector
//   updates its column and row stepping state on each accepted pixel, with adds and compares only.
// Path: a selected pixel is written into the queue at the accepting edge,
//   then the weight multiply loads the output register once the output slot
//   is free or being drained.
// Receiver stall: results collect in a 4-word queue plus the output
//   register; pixel.ready drops only when the queue is full.
// Reset: sizes return to 160x120 -> 64x64, selectors and position clear,
//   queue empties.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb565_nearest_downscaler_core import rgbds_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
  input  wire logic   clk,
  input  wire logic   rst,
  rgbds_pix_if.sink   pixel,
  rgbds_res_if.source result,
  rgbds_cfg_if.sink   cfg
);

  cfg_regs_t  regs;
  fifo_stat_t stat;
  pick_t      wr_entry, rd_entry;
  logic       push, pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.src_width  <= SRC_WIDTH_RESET;
      regs.src_height <= SRC_HEIGHT_RESET;
      regs.dst_width  <= DST_WIDTH_RESET;
      regs.dst_height <= DST_HEIGHT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_SRC_WIDTH:  regs.src_width  <= cfg.wdata;
        REG_SRC_HEIGHT: regs.src_height <= cfg.wdata;
        REG_DST_WIDTH:  regs.dst_width  <= cfg.wdata;
        REG_DST_HEIGHT: regs.dst_height <= cfg.wdata;
        default: ;
      endcase
    end
  end

  rgbds_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .regs  (regs),
    .pixel (pixel),
    .stat  (stat),
    .push  (push),
    .entry (wr_entry)
  );

  rgbds_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (rd_entry),
    .stat     (stat)
  );

  rgbds_back u_back (
    .clk    (clk),
    .rst    (rst),
    .stat   (stat),
    .entry  (rd_entry),
    .pop    (pop),
    .result (result)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    stat.count <= CNT_W'(FIFO_DEPTH))
    else $error("selector queue over its depth");

  a_no_phantom_result: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(!stat.empty))
    else $error("result raised with nothing queued");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    stat.full |-> !push)
    else $error("queue written while full");

endmodule

`default_nettype wire

### dv/rgb565_nearest_downscaler_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb565_nearest_downscaler_core_tb: self-checking bench for the downscaler
// Streams raster RGB565 pixels under many source/destination sizes, predicts
// every picked destination pixel and compares each result word by field.
// ----------------------------------------------------------------------------

module rgb565_nearest_downscaler_core_tb;
  import rgbds_pkg::*;

  localparam int MAX_SIZE     = MAX_DIM_DEFAULT;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 900;
  localparam int MAX_REPORTS  = 30;

  typedef struct packed {
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
    logic              frame_start;
  } src_pixel_t;

  typedef struct packed {
    logic [COORD_W-1:0] dest_col;
    logic [COORD_W-1:0] dest_row;
    logic [RED_W-1:0]   red_term;
    logic [GREEN_W-1:0] green_term;
    logic [BLUE_W-1:0]  blue_term;
    logic               last_of_frame;
  } dst_pixel_t;

  logic clk;
  logic rst;

  rgbds_pix_if pixel();
  rgbds_res_if result();
  rgbds_cfg_if cfg();

  rgb565_nearest_downscaler_core uut (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel),
    .result(result),
    .cfg   (cfg)
  );

  src_pixel_t  pending_pixels[$];
  dst_pixel_t  expected_picks[$];
  int unsigned items_sent;
  int unsigned errors;

  // driver / sink control
  logic        pix_fire;
  logic        pix_holding;
  int unsigned pix_gap;
  int unsigned res_stall;
  logic        pix_idle_on;
  logic        res_idle_on;
  int unsigned idle_cycles;

  // predictor copy of the size registers and the stepping state
  logic [CFG_W-1:0]   reg_src_w, reg_src_h, reg_dst_w, reg_dst_h;
  logic [COORD_W-1:0] pos_col, pos_row;
  logic [COORD_W-1:0] sel_col, pick_col, sel_row, pick_row;
  logic [CFG_W-1:0]   col_rem, row_rem;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input logic [CFG_W-1:0] hi);
    if (v == '0) return CFG_W'(1);
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CFG_W-1:0] extreme_size();
    case ($urandom_range(0, 6))
      0: return CFG_W'(0);
      1: return CFG_W'(1);
      2: return CFG_W'(2);
      3: return CFG_W'(1023);
      4: return CFG_W'(1024);
      5: return CFG_W'(1025);
      default: return CFG_W'(2047);
    endcase
  endfunction

  task automatic clear_frame_state();
    pos_col  = '0;
    pos_row  = '0;
    sel_col  = '0;
    col_rem  = '0;
    pick_col = '0;
    sel_row  = '0;
    row_rem  = '0;
    pick_row = '0;
  endtask

  // one source pixel through the nearest-neighbor selector
  task automatic predict_pick(input src_pixel_t px);
    logic [CFG_W-1:0]  sw, sh, dw, dh;
    logic              col_hit, row_hit;
    logic [BYTE_W-1:0] red8, green8, blue8;
    dst_pixel_t        word;
    sw = clamp_size(reg_src_w, CFG_W'(MAX_SIZE));
    sh = clamp_size(reg_src_h, CFG_W'(MAX_SIZE));
    dw = clamp_size(reg_dst_w, sw);
    dh = clamp_size(reg_dst_h, sh);

    if (px.frame_start) clear_frame_state();

    // head of each source row: column selector clears, row selector steps at most once; else column steps
    if (pos_col == '0) begin
      sel_col  = '0;
      col_rem  = '0;
      pick_col = '0;
      if (row_rem >= dh) begin
        sel_row = sel_row + 1'b1;
        row_rem = row_rem - dh;
      end
    end else if (col_rem >= dw) begin
      sel_col = sel_col + 1'b1;
      col_rem = col_rem - dw;
    end

    col_hit = (sel_col == pos_col) && (col_rem < dw) && (pick_col < dw);
    row_hit = (sel_row == pos_row) && (row_rem < dh) && (pick_row < dh);

    if (col_hit && row_hit) begin
      red8   = {px.second_byte[7:3], 3'b000};
      green8 = {px.second_byte[2:0], px.first_byte[7:5], 2'b00};
      blue8  = {px.first_byte[4:0], 3'b000};
      word.dest_col      = pick_col;
      word.dest_row      = pick_row;
      word.red_term      = RED_W'(red8 * RED_WEIGHT);
      word.green_term    = GREEN_W'(green8 * GREEN_WEIGHT);
      word.blue_term     = BLUE_W'(blue8 * BLUE_WEIGHT);
      word.last_of_frame = (pick_col == dw - 1'b1) && (pick_row == dh - 1'b1);
      expected_picks.push_back(word);
    end

    if (col_hit) begin
      pick_col = pick_col + 1'b1;
      col_rem  = col_rem + sw;
    end

    if (pos_col >= sw - 1'b1) begin
      pos_col = '0;
      if (row_hit) begin
        pick_row = pick_row + 1'b1;
        row_rem  = row_rem + sh;
      end
      if (pos_row >= sh - 1'b1) clear_frame_state();
      else pos_row = pos_row + 1'b1;
    end else begin
      pos_col = pos_col + 1'b1;
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // acceptance, register mirroring, prediction, checking and watchdog, all on the rising edge
  always @(posedge clk) begin
    dst_pixel_t want;
    logic       any_fire;
    if (rst) begin
      pix_fire    <= 1'b0;
      idle_cycles = 0;
      reg_src_w   = SRC_WIDTH_RESET;
      reg_src_h   = SRC_HEIGHT_RESET;
      reg_dst_w   = DST_WIDTH_RESET;
      reg_dst_h   = DST_HEIGHT_RESET;
      clear_frame_state();
    end else begin
      pix_fire <= pixel.valid && pixel.ready;
      any_fire = (pixel.valid && pixel.ready) || (result.valid && result.ready) ||
                 (cfg.valid && cfg.ready);

      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SRC_WIDTH:  reg_src_w = cfg.wdata;
          REG_SRC_HEIGHT: reg_src_h = cfg.wdata;
          REG_DST_WIDTH:  reg_dst_w = cfg.wdata;
          REG_DST_HEIGHT: reg_dst_h = cfg.wdata;
          default: ;
        endcase
      end

      if (result.valid && result.ready) begin
        if (expected_picks.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected result word, col %0d row %0d", $time,
                     result.dest_col, result.dest_row);
        end else begin
          want = expected_picks.pop_front();
          check_field("dest_col", want.dest_col, result.dest_col);
          check_field("dest_row", want.dest_row, result.dest_row);
          check_field("red_term", want.red_term, result.red_term);
          check_field("green_term", want.green_term, result.green_term);
          check_field("blue_term", want.blue_term, result.blue_term);
          check_field("last_of_frame", want.last_of_frame, result.last_of_frame);
        end
      end

      if (pixel.valid && pixel.ready)
        predict_pick({pixel.first_byte, pixel.second_byte, pixel.frame_start});

      if (any_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d words still expected", $time,
                 IDLE_LIMIT, expected_picks.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // pixel driver
  always @(negedge clk) begin
    src_pixel_t nxt;
    if (rst) begin
      pixel.valid <= 1'b0;
      pix_holding = 1'b0;
      pix_gap     = 0;
    end else begin
      if (pix_fire) begin
        pix_holding = 1'b0;
        pix_gap     = pix_idle_on ? gap_len() : 0;
      end
      if (!pix_holding) begin
        if (pix_gap > 0) begin
          pix_gap--;
        end else if (pending_pixels.size() > 0) begin
          nxt = pending_pixels.pop_front();
          pixel.first_byte  <= nxt.first_byte;
          pixel.second_byte <= nxt.second_byte;
          pixel.frame_start <= nxt.frame_start;
          pix_holding = 1'b1;
        end
      end
      pixel.valid <= pix_holding;
    end
  end

  // result sink with random stalls
  always @(negedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      res_stall = 0;
    end else begin
      if (res_stall == 0 && res_idle_on && $urandom_range(0, 3) == 0) res_stall = gap_len();
      if (res_stall > 0) begin
        res_stall--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  task automatic push_pixel(input logic [BYTE_W-1:0] lo, input logic [BYTE_W-1:0] hi,
                            input logic start);
    pending_pixels.push_back({lo, hi, start});
    items_sent++;
  endtask

  // every word sent, every result back, then room for a pick still in flight
  task automatic wait_drained();
    while (pending_pixels.size() != 0 || pix_holding || expected_picks.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.wdata <= value;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic write_sizes(input logic [CFG_W-1:0] sw, input logic [CFG_W-1:0] sh,
                             input logic [CFG_W-1:0] dw, input logic [CFG_W-1:0] dh,
                             input logic [3:0] mask);
    if (mask[0]) write_reg(REG_SRC_WIDTH, sw);
    if (mask[1]) write_reg(REG_SRC_HEIGHT, sh);
    if (mask[2]) write_reg(REG_DST_WIDTH, dw);
    if (mask[3]) write_reg(REG_DST_HEIGHT, dh);
  endtask

  initial begin
    logic [BYTE_W-1:0] lo_pat[8];
    logic [BYTE_W-1:0] hi_pat[8];
    logic [CFG_W-1:0]  sw, sh, dw, dh;
    int unsigned       phase, shape, count, frames, area;

    lo_pat = '{8'h00, 8'hFF, 8'h1F, 8'hE0, 8'h00, 8'h00, 8'hAA, 8'h55};
    hi_pat = '{8'h00, 8'hFF, 8'h00, 8'h00, 8'h07, 8'hF8, 8'h55, 8'hAA};

    rst               = 1'b1;
    pixel.valid       = 1'b0;
    pixel.first_byte  = '0;
    pixel.second_byte = '0;
    pixel.frame_start = 1'b0;
    result.ready      = 1'b0;
    cfg.valid         = 1'b0;
    cfg.index         = REG_SRC_WIDTH;
    cfg.wdata         = '0;
    pix_idle_on       = 1'b0;
    res_idle_on       = 1'b0;
    items_sent        = 0;
    errors            = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset sizes, a few pixels of a frame left unfinished
    for (int i = 0; i < 4; i++) push_pixel(lo_pat[i], hi_pat[i], i == 0);
    wait_drained();

    // 8x2 source, destination over-sized in width and zero in height:
    // every column of row 0 picked, row 1 silent, then wrap and a restart
    write_sizes(CFG_W'(8), CFG_W'(2), CFG_W'(2047), CFG_W'(0), 4'b1111);
    pix_idle_on = 1'b1;
    res_idle_on = 1'b1;
    for (int i = 0; i < 16; i++) push_pixel(lo_pat[i % 8], hi_pat[i % 8], i == 0);
    for (int i = 0; i < 4; i++) push_pixel(lo_pat[7 - i], hi_pat[7 - i], 1'b0);
    push_pixel(8'hFF, 8'h00, 1'b1);

    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      wait_drained();
      pix_idle_on = $urandom_range(0, 3) != 0;
      res_idle_on = $urandom_range(0, 3) != 0;

      sw = CFG_W'($urandom_range(0, 12));
      sh = CFG_W'($urandom_range(0, 10));
      dw = CFG_W'($urandom_range(0, sw + 3));
      dh = CFG_W'($urandom_range(0, sh + 3));
      if (phase == 3) begin
        sw = CFG_W'(2047); sh = CFG_W'(0); dw = CFG_W'(0); dh = CFG_W'(2047);
      end else if (phase == 7) begin
        sw = CFG_W'(1024); sh = CFG_W'(1025); dw = CFG_W'(1024); dh = CFG_W'(1);
      end else if (phase % 4 == 3) begin
        if ($urandom_range(0, 1)) sw = extreme_size();
        if ($urandom_range(0, 1)) sh = extreme_size();
        if ($urandom_range(0, 1)) dw = extreme_size();
        if ($urandom_range(0, 1)) dh = extreme_size();
      end
      // later phases keep some registers, so state carries across the write
      write_sizes(sw, sh, dw, dh, (phase < 8) ? 4'b1111 : 4'($urandom_range(1, 15)));

      area  = clamp_size(reg_src_w, CFG_W'(MAX_SIZE)) * clamp_size(reg_src_h, CFG_W'(MAX_SIZE));
      shape = $urandom_range(0, 9);
      if (shape < 6 && area <= 200) begin
        frames = $urandom_range(1, 3);
        repeat (frames)
          for (int p = 0; p < area; p++)
            push_pixel(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                       p == 0);
      end else if (shape < 8 || area > 200) begin
        count = $urandom_range(5, 120);
        repeat (count)
          push_pixel(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)), 1'b0);
      end else begin
        count = $urandom_range(10, 80);
        repeat (count)
          push_pixel(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                     $urandom_range(0, 9) == 0);
      end
      phase++;
    end

    wait_drained();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
